// ===== rtl/core/masked_nearest_point_search_core_assert.svh =====
// assertion helpers for the nearest point search core
`ifndef MASKED_NEAREST_POINT_SEARCH_CORE_ASSERT_SVH
`define MASKED_NEAREST_POINT_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define MNPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mnps assertion failed");

// next-cycle implication, disabled while reset is held
`define MNPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mnps assertion failed");

`endif

// ===== rtl/core/mnps_pkg.sv =====
package mnps_pkg;

    // fixed field widths
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // status traveling with each entry through the distance pipeline
    typedef struct packed {
        logic vld;
        logic elig;
    } t_tag;

endpackage

// ===== rtl/core/masked_nearest_point_search_core.sv =====
// load transfer: written in the accepting cycle, busy stays low, no result
// query transfer: n = min(node_count, MAX_POINTS) entries are scanned, none if n is
// zero; the distance pipeline drains, then the result strobe follows. one table
// entry is read per cycle through the single read port into the distance pipeline
// the receiver cannot stall; busy stays high until the result is issued
// synchronous active-low reset clears control state and node_count, not the table
module masked_nearest_point_search_core #(
    parameter int MAX_POINTS = 1024,
    parameter int GROUP_BITS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [10:0]                  i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [9:0]                   i_entry_index,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [GROUP_BITS-1:0]        i_group_mask,
    input  logic                         i_match_all,
    output logic                         o_result_valid,
    output logic                         o_found,
    output logic [9:0]                   o_best_index,
    output logic [2*COORD_BITS+1:0]      o_best_distance_sq
);
    import mnps_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int DW  = 2 * COORD_BITS + 2;
    localparam int CNW = (CNT_W > AW + 1) ? CNT_W : AW + 1;
    localparam int EW  = (AW > IDX_W) ? AW : IDX_W;

    // table storage
    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_z [MAX_POINTS];
    logic [GROUP_BITS-1:0] mem_m [MAX_POINTS];

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_node_count;
    logic [AW:0]           r_limit, n_limit;
    logic [AW:0]           r_scan_cnt;
    logic [COORD_BITS-1:0] r_q_x, r_q_y, r_q_z;
    logic [GROUP_BITS-1:0] r_q_mask;
    logic                  r_q_all;

    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y, r_rd_z;
    logic [GROUP_BITS-1:0] r_rd_mask;

    logic                  r_found;
    logic [AW-1:0]         r_best_idx;
    logic [DW-1:0]         r_best_dist;

    logic                  r_res_vld;
    logic                  r_res_found;
    logic [IDX_W-1:0]      r_res_idx;
    logic [DW-1:0]         r_res_dist;

    logic                  accept, ld_we, q_start, rd_en, emit;
    logic [EW:0]           ld_idx;
    logic [AW-1:0]         rd_addr;
    logic [CNW-1:0]        nc_ext;
    logic [EW-1:0]         best_ext;
    t_tag                  tag_a, tag_d;
    logic [AW-1:0]         idx_d;
    logic [DW-1:0]         dist_d;
    logic                  pipe_active;
    logic                  take_best;

    // transfer decode
    assign accept  = start && !busy;
    assign ld_idx  = (EW+1)'(i_entry_index);
    assign ld_we   = accept && (i_op == OP_LOAD) && (ld_idx < (EW+1)'(MAX_POINTS));
    assign q_start = accept && (i_op == OP_QUERY);
    assign rd_addr = r_scan_cnt[AW-1:0];
    assign busy    = (r_state != ST_IDLE);

    // scan length clamped to the table size
    assign nc_ext  = CNW'(r_node_count);
    assign n_limit = (nc_ext > CNW'(MAX_POINTS)) ? (AW+1)'(MAX_POINTS) : (AW+1)'(nc_ext);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (q_start) begin
                    n_state = (n_limit == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (r_scan_cnt == r_limit - 1'b1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !pipe_active) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // query capture and scan counter
    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_q_x    <= i_pos_x;
            r_q_y    <= i_pos_y;
            r_q_z    <= i_pos_z;
            r_q_mask <= i_group_mask;
            r_q_all  <= i_match_all;
            r_limit  <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
        end else if (q_start) begin
            r_scan_cnt <= '0;
        end else if (rd_en) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            mem_x[ld_idx[AW-1:0]] <= i_pos_x;
            mem_y[ld_idx[AW-1:0]] <= i_pos_y;
            mem_z[ld_idx[AW-1:0]] <= i_pos_z;
            mem_m[ld_idx[AW-1:0]] <= i_group_mask;
        end
        if (rd_en) begin
            r_rd_x    <= mem_x[rd_addr];
            r_rd_y    <= mem_y[rd_addr];
            r_rd_z    <= mem_z[rd_addr];
            r_rd_mask <= mem_m[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
    end

    // group eligibility of the entry just read
    always_comb begin
        tag_a.vld  = r_rd_vld;
        tag_a.elig = r_q_all || (|(r_rd_mask & r_q_mask));
    end

    mnps_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag_a),
        .i_index  (r_rd_idx),
        .i_pt_x   (r_rd_x),
        .i_pt_y   (r_rd_y),
        .i_pt_z   (r_rd_z),
        .i_q_x    (r_q_x),
        .i_q_y    (r_q_y),
        .i_q_z    (r_q_z),
        .o_tag    (tag_d),
        .o_index  (idx_d),
        .o_dist   (dist_d),
        .o_active (pipe_active)
    );

    // running minimum, strict compare keeps the lower index on a tie
    assign take_best = tag_d.vld && tag_d.elig && (!r_found || (dist_d < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (q_start) begin
            r_found <= 1'b0;
        end else if (take_best) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (take_best) begin
            r_best_idx  <= idx_d;
            r_best_dist <= dist_d;
        end
    end

    // result register
    assign best_ext = EW'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res_found <= r_found;
            r_res_idx   <= best_ext[IDX_W-1:0];
            r_res_dist  <= r_best_dist;
        end
    end

    assign o_result_valid     = r_res_vld;
    assign o_found            = r_res_found;
    assign o_best_index       = r_res_idx;
    assign o_best_distance_sq = r_res_dist;

endmodule

// ===== rtl/core/mnps_dist_unit.sv =====
module mnps_dist_unit #(
    parameter int COORD_BITS = 16,
    parameter int AW         = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mnps_pkg::t_tag            i_tag,
    input  logic [AW-1:0]             i_index,
    input  logic [COORD_BITS-1:0]     i_pt_x,
    input  logic [COORD_BITS-1:0]     i_pt_y,
    input  logic [COORD_BITS-1:0]     i_pt_z,
    input  logic [COORD_BITS-1:0]     i_q_x,
    input  logic [COORD_BITS-1:0]     i_q_y,
    input  logic [COORD_BITS-1:0]     i_q_z,
    output mnps_pkg::t_tag            o_tag,
    output logic [AW-1:0]             o_index,
    output logic [2*COORD_BITS+1:0]   o_dist,
    output logic                      o_active
);
    import mnps_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 2;

    logic [CB:0]     dx, dy, dz;
    logic [CB-1:0]   ax, ay, az;
    logic [2*CB-1:0] sq_x, sq_y, sq_z;

    t_tag            r_tag_b, r_tag_c, r_tag_d;
    logic [AW-1:0]   r_idx_b, r_idx_c, r_idx_d;
    logic [CB-1:0]   r_ax, r_ay, r_az;
    logic [2*CB-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic [DW-1:0]   r_sum;

    // sign-extended differences and their magnitudes
    always_comb begin
        dx = {i_pt_x[CB-1], i_pt_x} - {i_q_x[CB-1], i_q_x};
        dy = {i_pt_y[CB-1], i_pt_y} - {i_q_y[CB-1], i_q_y};
        dz = {i_pt_z[CB-1], i_pt_z} - {i_q_z[CB-1], i_q_z};
        ax = dx[CB] ? CB'(~dx + 1'b1) : dx[CB-1:0];
        ay = dy[CB] ? CB'(~dy + 1'b1) : dy[CB-1:0];
        az = dz[CB] ? CB'(~dz + 1'b1) : dz[CB-1:0];
    end

    // squares of the magnitudes
    assign sq_x = r_ax * r_ax;
    assign sq_y = r_ay * r_ay;
    assign sq_z = r_az * r_az;

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_b <= '0;
            r_tag_c <= '0;
            r_tag_d <= '0;
        end else begin
            r_tag_b <= i_tag;
            r_tag_c <= r_tag_b;
            r_tag_d <= r_tag_c;
        end
    end

    // data pipeline: magnitude, square, sum
    always_ff @(posedge i_clk) begin
        r_idx_b <= i_index;
        r_ax    <= ax;
        r_ay    <= ay;
        r_az    <= az;
        r_idx_c <= r_idx_b;
        r_sq_x  <= sq_x;
        r_sq_y  <= sq_y;
        r_sq_z  <= sq_z;
        r_idx_d <= r_idx_c;
        r_sum   <= DW'(r_sq_x) + DW'(r_sq_y) + DW'(r_sq_z);
    end

    assign o_tag    = r_tag_d;
    assign o_index  = r_idx_d;
    assign o_dist   = r_sum;
    assign o_active = r_tag_b.vld | r_tag_c.vld | r_tag_d.vld;

endmodule

// ===== rtl/core/mnps_checker.sv =====
`include "masked_nearest_point_search_core_assert.svh"

module mnps_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    i_op,
    input logic                    o_result_valid,
    input logic                    o_found,
    input logic [9:0]              o_best_index,
    input logic [2*COORD_BITS+1:0] o_best_distance_sq
);
    import mnps_pkg::*;

    // a result strobe lasts a single cycle
    `MNPS_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_valid, !o_result_valid)

    // a result only appears as a query finishes
    `MNPS_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_result_valid, $past(busy))

    // a load transfer never occupies the block
    `MNPS_ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n, start && !busy && i_op == OP_LOAD, !busy)

    // a query transfer always occupies the block
    `MNPS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_op == OP_QUERY, busy)

    // an empty result carries zero index and distance
    `MNPS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_result_valid && !o_found, o_best_index == '0 && o_best_distance_sq == '0)

endmodule

bind masked_nearest_point_search_core mnps_checker #(
    .COORD_BITS (COORD_BITS)
) u_mnps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_op               (i_op),
    .o_result_valid     (o_result_valid),
    .o_found            (o_found),
    .o_best_index       (o_best_index),
    .o_best_distance_sq (o_best_distance_sq)
);
